@@ sv/csfs_pkg.sv @@
// Shared types, widths and codes for the centripetal spline sampler.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package csfs_pkg;

	// Coordinate and internal widths
	localparam int COORD_W = 16;           // Q12.4 coordinates
	localparam int PT_W = COORD_W + 2;     // reflected points
	localparam int DIFF_W = PT_W + 1;      // point differences
	localparam int KNOT_W = 23;            // knot spacing, Q.12
	localparam int ACC_W = 64;             // wide datapath
	localparam int OPB_W = 24;             // narrow operand / divisor
	localparam int SQ_W = 56;              // root operand
	localparam int TAN_FRAC = 8;           // tangent fraction bits
	localparam int N_W = 6;                // samples register width
	localparam int N2_W = 11;
	localparam int N3_W = 16;
	localparam int MAX_SAMPLES_DEF = 32;
	localparam logic [N_W-1:0] N_RESET = N_W'(8);
	localparam logic [KNOT_W-1:0] ONE_KNOT = KNOT_W'(4096);

	// Shared unit operations
	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_DIV = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	typedef struct packed {
		logic start;
		logic [1:0] op;
		logic signed [ACC_W-1:0] a;
		logic [OPB_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic signed [ACC_W-1:0] res;
	} alu_rsp_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic last;
		logic degen;
	} sample_t;

endpackage

@@ sv/csfs_alu.sv @@
// Shared arithmetic unit: two-pass multiply on a 33 by 24 bit multiplier,
// bit-serial rounded divide and bit-pair integer square root. Depends on csfs_pkg.
`timescale 1ns / 1ps
module csfs_alu import csfs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	localparam int CNT_W = $clog2(ACC_W);
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int HALF_W = ACC_W / 2;
	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_DIV = 2'd1;
	localparam logic [1:0] A_SQRT = 2'd2;
	localparam logic [1:0] A_MUL = 2'd3;

	logic [1:0] mode_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [ACC_W-1:0] res_q;
	logic neg_q;
	logic [OPB_W-1:0] den_q;
	logic [OPB_W-1:0] rem_q;
	logic [ACC_W-1:0] quo_q;
	logic [SQ_W-1:0] sv_q, sr_q, sbit_q;
	logic [HALF_W-1:0] mhi_q;
	logic [OPB_W-1:0] mb_q;

	logic [HALF_W-1:0] mul_x;
	logic [OPB_W-1:0] mul_y;
	logic signed [HALF_W+OPB_W:0] prod;
	logic [ACC_W-1:0] div_mag;
	logic [OPB_W:0] rem_sh;
	logic div_ge;
	logic [ACC_W-1:0] quo_nxt;
	logic [SQ_W-1:0] s_try, sr_nxt;
	logic s_ge;

	// Multiplier: low half of the operand first, then the high half.
	// The low product is exact; only the low bits of the high product matter.
	assign mul_x = (mode_q == A_MUL) ? mhi_q : req.a[HALF_W-1:0];
	assign mul_y = (mode_q == A_MUL) ? mb_q : req.b;
	assign prod = $signed({1'b0, mul_x}) * $signed(mul_y);
	assign div_mag = req.a[ACC_W-1] ? ACC_W'(-req.a) : ACC_W'(req.a);

	// One quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[ACC_W-1]};
	assign div_ge = rem_sh >= {1'b0, den_q};
	assign quo_nxt = {quo_q[ACC_W-2:0], div_ge};

	// One root bit per cycle
	assign s_try = sr_q + sbit_q;
	assign s_ge = sv_q >= s_try;
	assign sr_nxt = s_ge ? (sr_q >> 1) + sbit_q : sr_q >> 1;

	// Mode sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= A_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (mode_q)
				A_IDLE: begin
					if (req.start) begin
						unique case (req.op)
							OP_DIV:  mode_q <= A_DIV;
							OP_SQRT: mode_q <= A_SQRT;
							default: mode_q <= A_MUL;
						endcase
					end
				end
				A_DIV: begin
					if (cnt_q == CNT_W'(ACC_W - 1)) begin
						mode_q <= A_IDLE;
						done_q <= 1'b1;
					end
				end
				A_SQRT: begin
					if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
						mode_q <= A_IDLE;
						done_q <= 1'b1;
					end
				end
				A_MUL: begin
					mode_q <= A_IDLE;
					done_q <= 1'b1;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (mode_q == A_IDLE && req.start) begin
			cnt_q <= '0;
			unique case (req.op)
				OP_DIV: begin
					neg_q <= req.a[ACC_W-1];
					den_q <= req.b;
					rem_q <= '0;
					quo_q <= div_mag + ACC_W'(req.b >> 1);
				end
				OP_SQRT: begin
					sv_q <= req.a[SQ_W-1:0];
					sr_q <= '0;
					sbit_q <= SQ_W'(1) << (SQ_W - 2);
				end
				default: begin
					res_q <= ACC_W'(prod);
					mhi_q <= req.a[ACC_W-1:HALF_W];
					mb_q <= req.b;
				end
			endcase
		end else if (mode_q == A_DIV) begin
			cnt_q <= cnt_q + CNT_W'(1);
			rem_q <= div_ge ? OPB_W'(rem_sh - {1'b0, den_q}) : rem_sh[OPB_W-1:0];
			quo_q <= quo_nxt;
			if (cnt_q == CNT_W'(ACC_W - 1)) begin
				res_q <= neg_q ? -$signed(quo_nxt) : $signed(quo_nxt);
			end
		end else if (mode_q == A_SQRT) begin
			cnt_q <= cnt_q + CNT_W'(1);
			sv_q <= s_ge ? sv_q - s_try : sv_q;
			sr_q <= sr_nxt;
			sbit_q <= sbit_q >> 2;
			if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
				res_q <= $signed(ACC_W'(sr_nxt));
			end
		end else if (mode_q == A_MUL) begin
			res_q <= res_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = res_q;

endmodule

@@ sv/csfs_seq.sv @@
// Sequencer: point window, interval setup, knots, tangents, coefficients
// and sample evaluation, all through the shared unit. Depends on csfs_pkg.
`timescale 1ns / 1ps
module csfs_seq import csfs_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] in_x,
	input  logic signed [COORD_W-1:0] in_y,
	input  logic                      in_final,
	input  logic [N_W-1:0]            n_cfg,
	output alu_req_t                  alu_req,
	input  alu_rsp_t                  alu_rsp,
	output logic                      smp_valid,
	input  logic                      smp_ready,
	output sample_t                   smp
);

	localparam int I_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (COORD_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_LEN_X    = 5'd1;
	localparam logic [4:0] ST_LEN_Y    = 5'd2;
	localparam logic [4:0] ST_LEN_SUM  = 5'd3;
	localparam logic [4:0] ST_ROOT1    = 5'd4;
	localparam logic [4:0] ST_ROOT2    = 5'd5;
	localparam logic [4:0] ST_KNOT     = 5'd6;
	localparam logic [4:0] ST_TAN_MUL  = 5'd7;
	localparam logic [4:0] ST_TAN_DIV  = 5'd8;
	localparam logic [4:0] ST_TAN_ACC  = 5'd9;
	localparam logic [4:0] ST_N_SQ     = 5'd10;
	localparam logic [4:0] ST_N_CUBE   = 5'd11;
	localparam logic [4:0] ST_N_DONE   = 5'd12;
	localparam logic [4:0] ST_SCL_MUL  = 5'd13;
	localparam logic [4:0] ST_SCL_WAIT = 5'd14;
	localparam logic [4:0] ST_SMP_MUL  = 5'd15;
	localparam logic [4:0] ST_SMP_WAIT = 5'd16;
	localparam logic [4:0] ST_SMP_DIV  = 5'd17;
	localparam logic [4:0] ST_EMIT     = 5'd18;

	logic [4:0] state_q;
	logic [1:0] seen_q;
	logic jobb_q;
	logic signed [COORD_W-1:0] win_x_q [3];
	logic signed [COORD_W-1:0] win_y_q [3];
	logic signed [PT_W-1:0] px_q [4];
	logic signed [PT_W-1:0] py_q [4];
	logic [KNOT_W-1:0] d_q [3];
	logic degen_q;
	logic [1:0] k_q;
	logic [2:0] j_q;
	logic axis_q;
	logic [1:0] hstep_q;
	logic [I_W-1:0] i_q;
	logic [N_W-1:0] n_q;
	logic [N2_W-1:0] n2_q;
	logic [N3_W-1:0] n3_q;
	logic signed [ACC_W-1:0] acc_q, t1_q;
	logic signed [ACC_W-1:0] cx_q [4];
	logic signed [ACC_W-1:0] cy_q [4];
	logic [COORD_W-1:0] smp_x_q, smp_y_q;
	alu_req_t alu_req_q;

	logic signed [COORD_W-1:0] p_x, p_y;
	logic [N_W-1:0] n_clamp;
	logic signed [DIFF_W-1:0] seg_dx, seg_dy;
	logic signed [PT_W-1:0] v0, v1, v2, v3;
	logic signed [DIFF_W-1:0] tan_diff;
	logic [KNOT_W-1:0] tan_den;
	logic tan_neg;
	logic signed [ACC_W-1:0] tan_sum;
	logic signed [DIFF_W-1:0] dv21;
	logic signed [ACC_W-1:0] c2_new, c3_new;
	logic signed [ACC_W-1:0] scl_a;
	logic [OPB_W-1:0] scl_b;
	logic signed [ACC_W-1:0] ca0, ca1, ca2, ca3;
	logic [KNOT_W-1:0] d1_fix;
	logic last_smp;

	function automatic logic signed [PT_W-1:0] reflect(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		return (PT_W'(a) <<< 1) - PT_W'(b);
	endfunction

	function automatic logic [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
		logic [COORD_W-1:0] r;
		if (v > SAT_HI) r = SAT_HI[COORD_W-1:0];
		else if (v < SAT_LO) r = SAT_LO[COORD_W-1:0];
		else r = v[COORD_W-1:0];
		return r;
	endfunction

	assign p_x = in_x;
	assign p_y = in_y;
	assign in_ready = (state_q == ST_IDLE);

	// Samples per interval, clamped to the supported range
	always_comb begin
		if (n_cfg == '0) n_clamp = N_W'(1);
		else if (n_cfg > N_W'(MAX_SAMPLES)) n_clamp = N_W'(MAX_SAMPLES);
		else n_clamp = n_cfg;
	end

	// Segment deltas for the knot being measured
	always_comb begin
		unique case (k_q)
			2'd0: begin
				seg_dx = DIFF_W'(px_q[1]) - DIFF_W'(px_q[0]);
				seg_dy = DIFF_W'(py_q[1]) - DIFF_W'(py_q[0]);
			end
			2'd1: begin
				seg_dx = DIFF_W'(px_q[2]) - DIFF_W'(px_q[1]);
				seg_dy = DIFF_W'(py_q[2]) - DIFF_W'(py_q[1]);
			end
			default: begin
				seg_dx = DIFF_W'(px_q[3]) - DIFF_W'(px_q[2]);
				seg_dy = DIFF_W'(py_q[3]) - DIFF_W'(py_q[2]);
			end
		endcase
	end

	// Coordinates of the axis in work
	assign v0 = axis_q ? py_q[0] : px_q[0];
	assign v1 = axis_q ? py_q[1] : px_q[1];
	assign v2 = axis_q ? py_q[2] : px_q[2];
	assign v3 = axis_q ? py_q[3] : px_q[3];

	// Tangent terms: three for the first tangent, three for the second
	always_comb begin
		unique case (j_q)
			3'd0: begin
				tan_diff = DIFF_W'(v1) - DIFF_W'(v0);
				tan_den = d_q[0];
				tan_neg = 1'b0;
			end
			3'd1: begin
				tan_diff = DIFF_W'(v2) - DIFF_W'(v0);
				tan_den = d_q[0] + d_q[1];
				tan_neg = 1'b1;
			end
			3'd2, 3'd3: begin
				tan_diff = DIFF_W'(v2) - DIFF_W'(v1);
				tan_den = d_q[1];
				tan_neg = 1'b0;
			end
			3'd4: begin
				tan_diff = DIFF_W'(v3) - DIFF_W'(v1);
				tan_den = d_q[1] + d_q[2];
				tan_neg = 1'b1;
			end
			default: begin
				tan_diff = DIFF_W'(v3) - DIFF_W'(v2);
				tan_den = d_q[2];
				tan_neg = 1'b0;
			end
		endcase
	end

	assign tan_sum = tan_neg ? acc_q - alu_rsp.res : acc_q + alu_rsp.res;

	// Cubic coefficients once both tangents of the axis are known
	assign dv21 = DIFF_W'(v2) - DIFF_W'(v1);
	assign c2_new = (ACC_W'(dv21) <<< 9) + (ACC_W'(dv21) <<< 8) - (t1_q <<< 1) - tan_sum;
	assign c3_new = -(ACC_W'(dv21) <<< 9) + t1_q + tan_sum;

	// Coefficient prescale by powers of N
	always_comb begin
		unique case (j_q)
			3'd0: begin scl_a = cx_q[2]; scl_b = OPB_W'(n_q); end
			3'd1: begin scl_a = cx_q[1]; scl_b = OPB_W'(n2_q); end
			3'd2: begin scl_a = cx_q[0]; scl_b = OPB_W'(n3_q); end
			3'd3: begin scl_a = cy_q[2]; scl_b = OPB_W'(n_q); end
			3'd4: begin scl_a = cy_q[1]; scl_b = OPB_W'(n2_q); end
			default: begin scl_a = cy_q[0]; scl_b = OPB_W'(n3_q); end
		endcase
	end

	assign ca0 = axis_q ? cy_q[0] : cx_q[0];
	assign ca1 = axis_q ? cy_q[1] : cx_q[1];
	assign ca2 = axis_q ? cy_q[2] : cx_q[2];
	assign ca3 = axis_q ? cy_q[3] : cx_q[3];

	assign d1_fix = (d_q[1] == '0) ? ONE_KNOT : d_q[1];
	assign last_smp = (N_W'(i_q) == n_q - N_W'(1));

	// Main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q <= 2'd0;
			jobb_q <= 1'b0;
			alu_req_q.start <= 1'b0;
		end else begin
			alu_req_q.start <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						n_q <= n_clamp;
						k_q <= 2'd0;
						jobb_q <= 1'b0;
						unique case (seen_q)
							2'd0: begin
								win_x_q[0] <= p_x;
								win_y_q[0] <= p_y;
								seen_q <= in_final ? 2'd0 : 2'd1;
							end
							2'd1: begin
								win_x_q[1] <= p_x;
								win_y_q[1] <= p_y;
								seen_q <= in_final ? 2'd0 : 2'd2;
								if (in_final) begin
									px_q[0] <= reflect(win_x_q[0], p_x);
									py_q[0] <= reflect(win_y_q[0], p_y);
									px_q[1] <= PT_W'(win_x_q[0]);
									py_q[1] <= PT_W'(win_y_q[0]);
									px_q[2] <= PT_W'(p_x);
									py_q[2] <= PT_W'(p_y);
									px_q[3] <= reflect(p_x, win_x_q[0]);
									py_q[3] <= reflect(p_y, win_y_q[0]);
									state_q <= ST_LEN_X;
								end
							end
							2'd2: begin
								px_q[0] <= reflect(win_x_q[0], win_x_q[1]);
								py_q[0] <= reflect(win_y_q[0], win_y_q[1]);
								px_q[1] <= PT_W'(win_x_q[0]);
								py_q[1] <= PT_W'(win_y_q[0]);
								px_q[2] <= PT_W'(win_x_q[1]);
								py_q[2] <= PT_W'(win_y_q[1]);
								px_q[3] <= PT_W'(p_x);
								py_q[3] <= PT_W'(p_y);
								win_x_q[2] <= p_x;
								win_y_q[2] <= p_y;
								jobb_q <= in_final;
								seen_q <= in_final ? 2'd0 : 2'd3;
								state_q <= ST_LEN_X;
							end
							default: begin
								px_q[0] <= PT_W'(win_x_q[0]);
								py_q[0] <= PT_W'(win_y_q[0]);
								px_q[1] <= PT_W'(win_x_q[1]);
								py_q[1] <= PT_W'(win_y_q[1]);
								px_q[2] <= PT_W'(win_x_q[2]);
								py_q[2] <= PT_W'(win_y_q[2]);
								px_q[3] <= PT_W'(p_x);
								py_q[3] <= PT_W'(p_y);
								win_x_q[0] <= win_x_q[1];
								win_y_q[0] <= win_y_q[1];
								win_x_q[1] <= win_x_q[2];
								win_y_q[1] <= win_y_q[2];
								win_x_q[2] <= p_x;
								win_y_q[2] <= p_y;
								jobb_q <= in_final;
								seen_q <= in_final ? 2'd0 : 2'd3;
								state_q <= ST_LEN_X;
							end
						endcase
					end
				end

				// Squared segment length, then two square roots
				ST_LEN_X: begin
					alu_req_q <= '{start: 1'b1, op: OP_MUL, a: ACC_W'(seg_dx),
						b: OPB_W'(seg_dx)};
					state_q <= ST_LEN_Y;
				end
				ST_LEN_Y: begin
					if (alu_rsp.done) begin
						acc_q <= alu_rsp.res;
						alu_req_q <= '{start: 1'b1, op: OP_MUL, a: ACC_W'(seg_dy),
							b: OPB_W'(seg_dy)};
						state_q <= ST_LEN_SUM;
					end
				end
				ST_LEN_SUM: begin
					if (alu_rsp.done) begin
						alu_req_q <= '{start: 1'b1, op: OP_SQRT,
							a: (acc_q + alu_rsp.res) <<< 16, b: '0};
						state_q <= ST_ROOT1;
					end
				end
				ST_ROOT1: begin
					if (alu_rsp.done) begin
						alu_req_q <= '{start: 1'b1, op: OP_SQRT, a: alu_rsp.res <<< 16,
							b: '0};
						state_q <= ST_ROOT2;
					end
				end
				ST_ROOT2: begin
					if (alu_rsp.done) begin
						d_q[k_q] <= alu_rsp.res[KNOT_W-1:0];
						if (k_q == 2'd2) begin
							state_q <= ST_KNOT;
						end else begin
							k_q <= k_q + 2'd1;
							state_q <= ST_LEN_X;
						end
					end
				end

				// Zero-length segments: flag and substitute spacings
				ST_KNOT: begin
					degen_q <= (d_q[0] == '0) || (d_q[1] == '0) || (d_q[2] == '0);
					d_q[1] <= d1_fix;
					if (d_q[0] == '0) d_q[0] <= d1_fix;
					if (d_q[2] == '0) d_q[2] <= d1_fix;
					acc_q <= '0;
					j_q <= 3'd0;
					axis_q <= 1'b0;
					state_q <= ST_TAN_MUL;
				end

				// Tangent terms: scale by the middle spacing, divide, accumulate
				ST_TAN_MUL: begin
					alu_req_q <= '{start: 1'b1, op: OP_MUL,
						a: ACC_W'(d_q[1]) <<< TAN_FRAC, b: OPB_W'(tan_diff)};
					state_q <= ST_TAN_DIV;
				end
				ST_TAN_DIV: begin
					if (alu_rsp.done) begin
						alu_req_q <= '{start: 1'b1, op: OP_DIV, a: alu_rsp.res,
							b: OPB_W'(tan_den)};
						state_q <= ST_TAN_ACC;
					end
				end
				ST_TAN_ACC: begin
					if (alu_rsp.done) begin
						j_q <= j_q + 3'd1;
						state_q <= ST_TAN_MUL;
						if (j_q == 3'd2) begin
							t1_q <= tan_sum;
							acc_q <= '0;
						end else begin
							acc_q <= tan_sum;
						end
						if (j_q == 3'd5) begin
							if (axis_q) begin
								cy_q[0] <= ACC_W'(v1) <<< TAN_FRAC;
								cy_q[1] <= t1_q;
								cy_q[2] <= c2_new;
								cy_q[3] <= c3_new;
								state_q <= ST_N_SQ;
							end else begin
								cx_q[0] <= ACC_W'(v1) <<< TAN_FRAC;
								cx_q[1] <= t1_q;
								cx_q[2] <= c2_new;
								cx_q[3] <= c3_new;
								axis_q <= 1'b1;
								j_q <= 3'd0;
								acc_q <= '0;
							end
						end
					end
				end

				// Powers of N
				ST_N_SQ: begin
					alu_req_q <= '{start: 1'b1, op: OP_MUL, a: ACC_W'(n_q),
						b: OPB_W'(n_q)};
					state_q <= ST_N_CUBE;
				end
				ST_N_CUBE: begin
					if (alu_rsp.done) begin
						n2_q <= alu_rsp.res[N2_W-1:0];
						alu_req_q <= '{start: 1'b1, op: OP_MUL, a: alu_rsp.res,
							b: OPB_W'(n_q)};
						state_q <= ST_N_DONE;
					end
				end
				ST_N_DONE: begin
					if (alu_rsp.done) begin
						n3_q <= alu_rsp.res[N3_W-1:0];
						j_q <= 3'd0;
						state_q <= ST_SCL_MUL;
					end
				end

				// Fold the powers of N into the coefficients
				ST_SCL_MUL: begin
					alu_req_q <= '{start: 1'b1, op: OP_MUL, a: scl_a, b: scl_b};
					state_q <= ST_SCL_WAIT;
				end
				ST_SCL_WAIT: begin
					if (alu_rsp.done) begin
						unique case (j_q)
							3'd0: cx_q[2] <= alu_rsp.res;
							3'd1: cx_q[1] <= alu_rsp.res;
							3'd2: cx_q[0] <= alu_rsp.res;
							3'd3: cy_q[2] <= alu_rsp.res;
							3'd4: cy_q[1] <= alu_rsp.res;
							default: cy_q[0] <= alu_rsp.res;
						endcase
						if (j_q == 3'd5) begin
							i_q <= '0;
							axis_q <= 1'b0;
							state_q <= ST_SMP_MUL;
						end else begin
							j_q <= j_q + 3'd1;
							state_q <= ST_SCL_MUL;
						end
					end
				end

				// Horner evaluation of one axis at sample i
				ST_SMP_MUL: begin
					alu_req_q <= '{start: 1'b1, op: OP_MUL, a: ca3, b: OPB_W'(i_q)};
					hstep_q <= 2'd0;
					state_q <= ST_SMP_WAIT;
				end
				ST_SMP_WAIT: begin
					if (alu_rsp.done) begin
						unique case (hstep_q)
							2'd0: begin
								alu_req_q <= '{start: 1'b1, op: OP_MUL,
									a: alu_rsp.res + ca2, b: OPB_W'(i_q)};
								hstep_q <= 2'd1;
							end
							2'd1: begin
								alu_req_q <= '{start: 1'b1, op: OP_MUL,
									a: alu_rsp.res + ca1, b: OPB_W'(i_q)};
								hstep_q <= 2'd2;
							end
							default: begin
								alu_req_q <= '{start: 1'b1, op: OP_DIV,
									a: alu_rsp.res + ca0, b: OPB_W'({n3_q, 8'b0})};
								state_q <= ST_SMP_DIV;
							end
						endcase
					end
				end
				ST_SMP_DIV: begin
					if (alu_rsp.done) begin
						if (axis_q) begin
							smp_y_q <= sat_coord(alu_rsp.res);
							state_q <= ST_EMIT;
						end else begin
							smp_x_q <= sat_coord(alu_rsp.res);
							axis_q <= 1'b1;
							state_q <= ST_SMP_MUL;
						end
					end
				end

				// Hand the sample to the output register
				ST_EMIT: begin
					if (smp_ready) begin
						axis_q <= 1'b0;
						if (last_smp) begin
							if (jobb_q) begin
								// Flush interval: window end reflected
								jobb_q <= 1'b0;
								k_q <= 2'd0;
								px_q[0] <= PT_W'(win_x_q[0]);
								py_q[0] <= PT_W'(win_y_q[0]);
								px_q[1] <= PT_W'(win_x_q[1]);
								py_q[1] <= PT_W'(win_y_q[1]);
								px_q[2] <= PT_W'(win_x_q[2]);
								py_q[2] <= PT_W'(win_y_q[2]);
								px_q[3] <= reflect(win_x_q[2], win_x_q[1]);
								py_q[3] <= reflect(win_y_q[2], win_y_q[1]);
								state_q <= ST_LEN_X;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							i_q <= i_q + I_W'(1);
							state_q <= ST_SMP_MUL;
						end
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign alu_req = alu_req_q;
	assign smp_valid = (state_q == ST_EMIT);
	assign smp.x = smp_x_q;
	assign smp.y = smp_y_q;
	assign smp.last = last_smp && !jobb_q;
	assign smp.degen = degen_q;

endmodule

@@ sv/centripetal_spline_fixed_samples_unit.sv @@
// Top level of the centripetal Catmull-Rom sampler: configuration register,
// output register, sequencer and shared arithmetic unit. Depends on csfs_pkg.
//
//  Channel  Direction  Signals                       Beat contents
//  s_       in         s_tvalid/s_tready/s_tdata/     point_x, point_y; tlast = final_point
//                      s_tlast
//  m_       out        m_tvalid/m_tready/m_tdata/     sample_x, sample_y; tlast = last_of_run;
//                      m_tlast/m_tuser               tuser = degenerate
//  cfg      in         cfg_we/cfg_wdata              samples_per_interval
//
// A point that opens no interval is only stored in the point window. Each interval
// runs on the one-bit-per-cycle divider and the two-pass multiply of the shared
// unit; a final point may run two intervals back to back. s_tready is high only
// while the sequencer is idle. A stalled m_ channel holds the sequencer at the
// next sample. Reset clears the point window.
`timescale 1ns / 1ps
module centripetal_spline_fixed_samples_unit import csfs_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [2*COORD_W-1:0] s_tdata,    // point_x, point_y
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [2*COORD_W-1:0] m_tdata,    // sample_x, sample_y
	output logic                 m_tlast,
	output logic [0:0]           m_tuser,    // degenerate
	input  logic                 cfg_we,
	input  logic [N_W-1:0]       cfg_wdata
);

	logic [N_W-1:0] n_cfg_q;
	logic out_valid_q;
	sample_t out_q;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	logic smp_valid, smp_ready;
	sample_t smp;

	// Samples-per-interval register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_cfg_q <= N_RESET;
		end else if (cfg_we) begin
			n_cfg_q <= cfg_wdata;
		end
	end

	csfs_seq #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_x      ($signed(s_tdata[COORD_W-1:0])),
		.in_y      ($signed(s_tdata[2*COORD_W-1:COORD_W])),
		.in_final  (s_tlast),
		.n_cfg     (n_cfg_q),
		.alu_req   (alu_req),
		.alu_rsp   (alu_rsp),
		.smp_valid (smp_valid),
		.smp_ready (smp_ready),
		.smp       (smp)
	);

	csfs_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// Output register: takes a new beat when empty or being drained
	assign smp_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (smp_valid && smp_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (smp_valid && smp_ready) begin
			out_q <= smp;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_q.y, out_q.x};
	assign m_tlast = out_q.last;
	assign m_tuser = out_q.degen;

endmodule

@@ tb/sv/tb_centripetal_spline_fixed_samples_unit.sv @@
// Self-checking testbench for the centripetal spline sampler: streams control
// point chains under several sample counts and checks every sample beat.
// Depends on csfs_pkg and centripetal_spline_fixed_samples_unit.
`timescale 1ns / 1ps

typedef bit [63:0] u64;

typedef struct {
	bit [15:0] x;
	bit [15:0] y;
	bit        last;
	bit        degen;
} spline_sample_t;

class spline_scoreboard;
	u64 win_x[3];
	u64 win_y[3];
	int unsigned pts_held;
	int unsigned n_cfg;
	spline_sample_t expected_samples[$];
	int unsigned errors;
	int unsigned samples_checked;

	function new();
		pts_held = 0;
		n_cfg = 8;
		errors = 0;
		samples_checked = 0;
		for (int k = 0; k < 3; k++) begin
			win_x[k] = 0;
			win_y[k] = 0;
		end
	endfunction

	function void set_samples(int unsigned v);
		n_cfg = v & 63;
	endfunction

	function u64 sext16(bit [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// Rounded division, ties away from zero, on a signed 64-bit numerator.
	function u64 rdiv(u64 num, u64 den);
		u64 m, q;
		if (den == 0) return 0;
		m = num[63] ? -num : num;
		q = (m + den / 2) / den;
		return num[63] ? -q : q;
	endfunction

	function u64 sqrt_floor(u64 v);
		u64 r, b;
		r = 0;
		b = u64'(1) << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function u64 spacing(u64 ax, u64 ay, u64 bx, u64 by);
		u64 dx, dy, l2;
		dx = bx - ax;
		dy = by - ay;
		l2 = dx * dx + dy * dy;
		return sqrt_floor(sqrt_floor(l2 << 16) << 16);
	endfunction

	function u64 tangent(u64 vp, u64 vh, u64 vn, u64 da, u64 db, u64 scale);
		u64 s;
		s = scale << 8;
		return rdiv(s * (vh - vp), da) - rdiv(s * (vn - vp), da + db) + rdiv(s * (vn - vh), db);
	endfunction

	// Appends the N samples of the interval between points 1 and 2.
	function void interval(u64 px[4], u64 py[4], u64 n, ref spline_sample_t run[$]);
		u64 d0, d1, d2, n3, t1, t2, num;
		u64 cf[2][4];
		u64 res[2];
		bit degen;
		spline_sample_t smp;
		d0 = spacing(px[0], py[0], px[1], py[1]);
		d1 = spacing(px[1], py[1], px[2], py[2]);
		d2 = spacing(px[2], py[2], px[3], py[3]);
		degen = (d0 == 0) || (d1 == 0) || (d2 == 0);
		if (d1 == 0) d1 = 4096;
		if (d0 == 0) d0 = d1;
		if (d2 == 0) d2 = d1;
		n3 = n * n * n;
		for (int a = 0; a < 2; a++) begin
			u64 v[4];
			foreach (v[k]) v[k] = (a == 0) ? px[k] : py[k];
			t1 = tangent(v[0], v[1], v[2], d0, d1, d1);
			t2 = tangent(v[1], v[2], v[3], d1, d2, d1);
			cf[a][0] = v[1] << 8;
			cf[a][1] = t1;
			cf[a][2] = 768 * (v[2] - v[1]) - 2 * t1 - t2;
			cf[a][3] = 512 * (v[1] - v[2]) + t1 + t2;
		end
		for (u64 i = 0; i < n; i++) begin
			for (int a = 0; a < 2; a++) begin
				num = cf[a][0] * n3 + cf[a][1] * i * n * n + cf[a][2] * i * i * n
					+ cf[a][3] * i * i * i;
				res[a] = rdiv(num, n3 << 8);
				if ($signed(res[a]) > 64'sd32767) res[a] = 32767;
				else if ($signed(res[a]) < -64'sd32768) res[a] = -u64'(32768);
			end
			smp.x = res[0][15:0];
			smp.y = res[1][15:0];
			smp.last = 0;
			smp.degen = degen;
			run.push_back(smp);
		end
	endfunction

	// Notes one accepted control point and queues the samples it causes.
	function void note_point(bit [15:0] xin, bit [15:0] yin, bit fin);
		u64 px, py, n;
		u64 qx[4], qy[4];
		spline_sample_t run[$];
		px = sext16(xin);
		py = sext16(yin);
		n = (n_cfg < 1) ? 1 : (n_cfg > 32) ? 32 : n_cfg;
		case (pts_held)
			0: begin
				win_x[0] = px;
				win_y[0] = py;
				pts_held = 1;
			end
			1: begin
				win_x[1] = px;
				win_y[1] = py;
				pts_held = 2;
				if (fin) begin
					qx = '{2 * win_x[0] - win_x[1], win_x[0], win_x[1], 2 * win_x[1] - win_x[0]};
					qy = '{2 * win_y[0] - win_y[1], win_y[0], win_y[1], 2 * win_y[1] - win_y[0]};
					interval(qx, qy, n, run);
				end
			end
			2: begin
				qx = '{2 * win_x[0] - win_x[1], win_x[0], win_x[1], px};
				qy = '{2 * win_y[0] - win_y[1], win_y[0], win_y[1], py};
				interval(qx, qy, n, run);
				if (fin) begin
					qx = '{win_x[0], win_x[1], px, 2 * px - win_x[1]};
					qy = '{win_y[0], win_y[1], py, 2 * py - win_y[1]};
					interval(qx, qy, n, run);
				end
				win_x[2] = px;
				win_y[2] = py;
				pts_held = 3;
			end
			default: begin
				qx = '{win_x[0], win_x[1], win_x[2], px};
				qy = '{win_y[0], win_y[1], win_y[2], py};
				interval(qx, qy, n, run);
				if (fin) begin
					qx = '{win_x[1], win_x[2], px, 2 * px - win_x[2]};
					qy = '{win_y[1], win_y[2], py, 2 * py - win_y[2]};
					interval(qx, qy, n, run);
				end
				win_x[0] = win_x[1];
				win_y[0] = win_y[1];
				win_x[1] = win_x[2];
				win_y[1] = win_y[2];
				win_x[2] = px;
				win_y[2] = py;
				pts_held = 3;
			end
		endcase
		if (fin) pts_held = 0;
		if (run.size() > 0) run[run.size() - 1].last = 1;
		foreach (run[k]) expected_samples.push_back(run[k]);
	endfunction

	// Compares one accepted sample beat with the oldest expectation.
	function void check_sample(bit [15:0] x, bit [15:0] y, bit last, bit degen);
		spline_sample_t e;
		samples_checked++;
		if (expected_samples.size() == 0) begin
			$error("unexpected sample beat x=%0h y=%0h", x, y);
			errors++;
			return;
		end
		e = expected_samples.pop_front();
		if (x !== e.x) begin
			$error("sample_x expected %0h actual %0h", e.x, x);
			errors++;
		end
		if (y !== e.y) begin
			$error("sample_y expected %0h actual %0h", e.y, y);
			errors++;
		end
		if (last !== e.last) begin
			$error("last_of_run expected %0b actual %0b", e.last, last);
			errors++;
		end
		if (degen !== e.degen) begin
			$error("degenerate expected %0b actual %0b", e.degen, degen);
			errors++;
		end
	endfunction
endclass

module tb_centripetal_spline_fixed_samples_unit;
	import csfs_pkg::*;

	localparam int STALL_LIMIT = 60000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [2*COORD_W-1:0] s_tdata;    // point_x, point_y
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [2*COORD_W-1:0] m_tdata;    // sample_x, sample_y
	logic                 m_tlast;
	logic [0:0]           m_tuser;    // degenerate
	logic                 cfg_we;
	logic [N_W-1:0]       cfg_wdata;

	spline_scoreboard sb;
	bit idle_en;
	int unsigned points_sent;
	int unsigned settings_used;
	int unsigned quiet_cycles;

	centripetal_spline_fixed_samples_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Sample sink with random stall bursts.
	initial begin
		int unsigned hold;
		m_tready = 0;
		hold = 0;
		forever begin
			if (hold > 0) begin
				hold--;
				m_tready <= 0;
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				hold = $urandom_range(1, 7) - 1;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_sample(m_tdata[15:0], m_tdata[31:16], m_tlast, m_tuser[0]);
		end
	end

	// Watchdog on cycles with no beat on either channel.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_point(bit [15:0] x, bit [15:0] y, bit fin);
		s_tvalid <= 1;
		s_tdata <= {y, x};
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		sb.note_point(x, y, fin);
		points_sent++;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Writes the sample count once all samples are out and the block is idle.
	task automatic write_samples(bit [5:0] v);
		s_tvalid <= 0;
		while (sb.expected_samples.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_samples(v);
		settings_used++;
	endtask

	function automatic bit [15:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 16'h7fff - 16'($urandom_range(0, 3));
			1: return 16'h8000 + 16'($urandom_range(0, 3));
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 4000)) - 2000);
		endcase
	endfunction

	// One chain of control points with random content, sometimes repeated points.
	task automatic send_chain(int unsigned len);
		bit [15:0] x, y;
		x = rand_coord();
		y = rand_coord();
		for (int unsigned k = 0; k < len; k++) begin
			if ($urandom_range(0, 7) != 0) begin
				if ($urandom_range(0, 3) == 0) begin
					x = rand_coord();
					y = rand_coord();
				end else begin
					x = x + 16'($signed($urandom_range(0, 800)) - 400);
					y = y + 16'($signed($urandom_range(0, 800)) - 400);
				end
			end
			send_point(x, y, k == len - 1);
		end
	endtask

	initial begin
		int unsigned budget;
		bit [5:0] phase_n[6];
		sb = new();
		idle_en = 1;
		points_sent = 0;
		settings_used = 0;
		quiet_cycles = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tlast = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: lone final point, two-point chain, repeated points, extremes.
		send_point(16'h0010, 16'h0020, 1);
		send_point(16'h8000, 16'h7fff, 0);
		send_point(16'h7fff, 16'h8000, 1);
		send_point(16'h0100, 16'h0100, 0);
		send_point(16'h0100, 16'h0100, 1);
		send_point(16'h0000, 16'h0000, 0);
		send_point(16'h0000, 16'h0000, 0);
		send_point(16'h0040, 16'h0000, 0);
		send_point(16'h0040, 16'h0000, 0);
		send_point(16'h0080, 16'h0030, 1);
		send_point(16'h8000, 16'h8000, 0);
		send_point(16'h7fff, 16'h7fff, 0);
		send_point(16'h8000, 16'h7fff, 0);
		send_point(16'h7fff, 16'h8000, 1);
		write_samples(6'd1);
		send_point(16'h0010, 16'hfff0, 0);
		send_point(16'h0050, 16'h0020, 0);
		send_point(16'hffa0, 16'h0070, 1);
		write_samples(6'd32);
		send_point(16'h0200, 16'h0000, 0);
		send_point(16'h0000, 16'h0200, 0);
		send_point(16'hfe00, 16'h0000, 1);
		write_samples(6'd0);
		send_point(16'h0001, 16'h0002, 0);
		send_point(16'h0003, 16'h0005, 1);
		write_samples(6'd63);
		send_point(16'h0100, 16'h0100, 0);
		send_point(16'h0300, 16'hff00, 1);

		// Random chains over several settings; the last phase runs without idling.
		phase_n = '{6'd8, 6'd3, 6'd1, 6'd33, 6'd5, 6'd2};
		foreach (phase_n[ph]) begin
			write_samples(phase_n[ph] == 6'd33 ? 6'd33 : phase_n[ph]);
			if (ph == 5) idle_en = 0;
			budget = (phase_n[ph] > 8) ? 16 : 85;
			while (budget > 0) begin
				int unsigned len;
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
				if (len > budget) len = budget;
				send_chain(len);
				budget -= len;
			end
		end
		s_tvalid <= 0;

		while (sb.expected_samples.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.expected_samples.size() != 0) begin
			$error("%0d expected samples never arrived", sb.expected_samples.size());
			sb.errors++;
		end
		$display("Sent %0d control points under %0d sample-count settings;",
			points_sent, settings_used + 1);
		$display("checked %0d sample beats.", sb.samples_checked);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

@@ files.f @@
sv/csfs_pkg.sv
sv/csfs_alu.sv
sv/csfs_seq.sv
sv/centripetal_spline_fixed_samples_unit.sv
tb/sv/tb_centripetal_spline_fixed_samples_unit.sv
